// ----- rtl/ecap_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecap_pkg
// Shared constants, micro-operation codes and control structs of the
// prime-field affine point adder.
// ----------------------------------------------------------------------------
package ecap_pkg;

  localparam int FIELD_BITS_DEF = 16;
  localparam int MODULUS_RST    = 29;
  localparam int COEF_A_RST     = 7;
  localparam int THREE          = 3;

  // Configuration register indexes
  localparam int REG_IDX_BITS        = 1;
  localparam logic [REG_IDX_BITS-1:0] REG_MODULUS = 1'b0;
  localparam logic [REG_IDX_BITS-1:0] REG_COEF_A  = 1'b1;

  // Datapath micro-operations
  localparam int OP_BITS = 5;
  localparam logic [OP_BITS-1:0] OP_NONE     = 5'd0;
  localparam logic [OP_BITS-1:0] OP_RED_X1   = 5'd1;
  localparam logic [OP_BITS-1:0] OP_RED_Y1   = 5'd2;
  localparam logic [OP_BITS-1:0] OP_RED_X2   = 5'd3;
  localparam logic [OP_BITS-1:0] OP_RED_Y2   = 5'd4;
  localparam logic [OP_BITS-1:0] OP_RED_A    = 5'd5;
  localparam logic [OP_BITS-1:0] OP_CHORD    = 5'd6;
  localparam logic [OP_BITS-1:0] OP_SQ       = 5'd7;
  localparam logic [OP_BITS-1:0] OP_TRIPLE   = 5'd8;
  localparam logic [OP_BITS-1:0] OP_TANGENT  = 5'd9;
  localparam logic [OP_BITS-1:0] OP_INV_INIT = 5'd10;
  localparam logic [OP_BITS-1:0] OP_DIV      = 5'd11;
  localparam logic [OP_BITS-1:0] OP_QMUL     = 5'd12;
  localparam logic [OP_BITS-1:0] OP_INV_STEP = 5'd13;
  localparam logic [OP_BITS-1:0] OP_SLOPE    = 5'd14;
  localparam logic [OP_BITS-1:0] OP_MSQ      = 5'd15;
  localparam logic [OP_BITS-1:0] OP_X3       = 5'd16;
  localparam logic [OP_BITS-1:0] OP_MY       = 5'd17;
  localparam logic [OP_BITS-1:0] OP_FIN      = 5'd18;
  localparam logic [OP_BITS-1:0] OP_INF      = 5'd19;

  typedef struct packed {
    logic               load;
    logic               go;
    logic [OP_BITS-1:0] op;
  } ecap_cmd_t;

  typedef struct packed {
    logic done;
    logic eqx;
    logic opp;
    logic p_small;
    logic r1_zero;
  } ecap_sts_t;

  // Operations that run on the multicycle engine
  function automatic logic is_multi(input logic [OP_BITS-1:0] op);
    logic m;
    case (op) inside
      OP_RED_X1, OP_RED_Y1, OP_RED_X2, OP_RED_Y2, OP_RED_A,
      OP_SQ, OP_TRIPLE, OP_DIV, OP_QMUL, OP_SLOPE, OP_MSQ, OP_MY: m = 1'b1;
      default: m = 1'b0;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ecap_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecap_if
// Valid/ready channels carrying point pairs in and sums out.
// ----------------------------------------------------------------------------
interface ecap_in_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] px;
  logic [W-1:0] py;
  logic [W-1:0] qx;
  logic [W-1:0] qy;
  modport source (output valid, px, py, qx, qy, input ready);
  modport sink   (input valid, px, py, qx, qy, output ready);
endinterface

interface ecap_out_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] sum_x;
  logic [W-1:0] sum_y;
  logic         at_infinity;
  modport source (output valid, sum_x, sum_y, at_infinity, input ready);
  modport sink   (input valid, sum_x, sum_y, at_infinity, output ready);
endinterface
`default_nettype wire

// ----- rtl/ecap_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecap_ctrl
// Sequencer: walks the micro-operation program and runs the handshakes.
// ----------------------------------------------------------------------------
module ecap_ctrl (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic in_valid,
  output                     logic in_ready,
  output                     logic out_valid,
  input  wire                logic out_ready,
  input  wire ecap_pkg::ecap_sts_t sts,
  output      ecap_pkg::ecap_cmd_t cmd
);
  import ecap_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]         state, state_next;
  logic [OP_BITS-1:0] op, op_next;

  function automatic logic [OP_BITS-1:0] follow(input logic [OP_BITS-1:0] o,
                                                input ecap_sts_t s);
    logic [OP_BITS-1:0] n;
    case (o)
      OP_RED_X1:   n = OP_RED_Y1;
      OP_RED_Y1:   n = OP_RED_X2;
      OP_RED_X2:   n = OP_RED_Y2;
      OP_RED_Y2:   n = OP_RED_A;
      OP_RED_A:    n = (s.eqx && s.opp) ? OP_INF : (s.eqx ? OP_SQ : OP_CHORD);
      OP_CHORD:    n = OP_INV_INIT;
      OP_SQ:       n = OP_TRIPLE;
      OP_TRIPLE:   n = OP_TANGENT;
      OP_TANGENT:  n = OP_INV_INIT;
      OP_INV_INIT: n = OP_DIV;
      OP_DIV:      n = OP_QMUL;
      OP_QMUL:     n = OP_INV_STEP;
      OP_INV_STEP: n = OP_DIV;
      OP_SLOPE:    n = OP_MSQ;
      OP_MSQ:      n = OP_X3;
      OP_X3:       n = OP_MY;
      OP_MY:       n = OP_FIN;
      default:     n = OP_NONE;
    endcase
    return n;
  endfunction

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    in_ready   = (state == S_IDLE);
    out_valid  = (state == S_OUT);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          op_next    = sts.p_small ? OP_INF : OP_RED_X1;
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        // Euclid ends once the remainder reaches zero
        if (op == OP_DIV && sts.r1_zero) begin
          op_next = OP_SLOPE;
        end else begin
          cmd.go = 1'b1;
          cmd.op = op;
          if (is_multi(op)) begin
            state_next = S_WAIT;
          end else if (op == OP_FIN || op == OP_INF) begin
            state_next = S_OUT;
          end else begin
            op_next = follow(op, sts);
          end
        end
      end
      S_WAIT: begin
        if (sts.done) begin
          op_next    = follow(op, sts);
          state_next = S_ISSUE;
        end
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_NONE;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ecap_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecap_dp
// Datapath: coordinate registers, serial modular multiplier, restoring
// divider for the Euclid quotients, and the result word.
// ----------------------------------------------------------------------------
module ecap_dp #(
  parameter int W = 16
) (
  input  wire                 logic                              clk,
  input  wire                 logic                              rst,
  input  wire                 logic                              cfg_we,
  input  wire                 logic [ecap_pkg::REG_IDX_BITS-1:0] cfg_index,
  input  wire                 logic [W-1:0]                      cfg_data,
  input  wire                 logic [W-1:0]                      px,
  input  wire                 logic [W-1:0]                      py,
  input  wire                 logic [W-1:0]                      qx,
  input  wire                 logic [W-1:0]                      qy,
  input  wire ecap_pkg::ecap_cmd_t                               cmd,
  output      ecap_pkg::ecap_sts_t                               sts,
  output                      logic [W-1:0]                      sum_x,
  output                      logic [W-1:0]                      sum_y,
  output                      logic                              at_infinity
);
  import ecap_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0] modulus, coef_a;
  logic [W-1:0] px_r, py_r, qx_r, qy_r;
  logic [W-1:0] x1, y1, x2, y2, aa, num, den, acc, m, x3;
  logic [W-1:0] r0, r1, t0, t1, rem, dq;
  logic [W-1:0] ma, mb, mr;
  logic [CW-1:0] cnt;
  logic          busy, done;
  logic [OP_BITS-1:0] cur_op;

  logic [W-1:0] three, neg_y2, qm, one;
  logic [W-1:0] mr_dbl, mr_next, rem_next;
  logic [W:0]   trial;
  logic         ge;

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] p);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, p}) s = s - {1'b0, p};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sub_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] p);
    return (a >= b) ? (a - b) : (a + p - b);
  endfunction

  assign one    = W'(1);
  assign three  = (modulus == W'(2)) ? one : ((modulus == W'(3)) ? '0 : W'(THREE));
  assign neg_y2 = (y2 == '0) ? '0 : (modulus - y2);
  assign qm     = (dq >= modulus) ? (dq - modulus) : dq;

  // One multiplier step: double, then add the multiplicand on a set bit
  assign mr_dbl  = add_mod(mr, mr, modulus);
  assign mr_next = mb[W-1] ? add_mod(mr_dbl, ma, modulus) : mr_dbl;

  // One restoring divider step
  assign trial    = {rem, dq[W-1]};
  assign ge       = (trial >= {1'b0, r1});
  assign rem_next = ge ? W'(trial - {1'b0, r1}) : trial[W-1:0];

  assign sts.done    = done;
  assign sts.eqx     = (x1 == x2);
  assign sts.opp     = (y1 == neg_y2);
  assign sts.p_small = (modulus < W'(2));
  assign sts.r1_zero = (r1 == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= W'(MODULUS_RST);
      coef_a  <= W'(COEF_A_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODULUS: modulus <= cfg_data;
        REG_COEF_A:  coef_a  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Engine control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
      cur_op <= OP_NONE;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (cmd.go && is_multi(cmd.op)) begin
        busy   <= 1'b1;
        cnt    <= CW'(W);
        cur_op <= cmd.op;
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r <= px;
      py_r <= py;
      qx_r <= qx;
      qy_r <= qy;
    end

    if (busy) begin
      if (cur_op == OP_DIV) begin
        rem <= rem_next;
        dq  <= {dq[W-2:0], ge};
      end else begin
        mr <= mr_next;
        mb <= {mb[W-2:0], 1'b0};
      end
    end

    // Retire multicycle results
    if (done) begin
      case (cur_op)
        OP_RED_X1: x1 <= mr;
        OP_RED_Y1: y1 <= mr;
        OP_RED_X2: x2 <= mr;
        OP_RED_Y2: y2 <= mr;
        OP_RED_A:  aa <= mr;
        OP_SLOPE:  m  <= mr;
        OP_SQ, OP_TRIPLE, OP_QMUL, OP_MSQ, OP_MY: acc <= mr;
        default: ;
      endcase
    end

    if (cmd.go) begin
      mr <= '0;
      case (cmd.op)
        OP_RED_X1: begin ma <= one; mb <= px_r; end
        OP_RED_Y1: begin ma <= one; mb <= py_r; end
        OP_RED_X2: begin ma <= one; mb <= qx_r; end
        OP_RED_Y2: begin ma <= one; mb <= qy_r; end
        OP_RED_A:  begin ma <= one; mb <= coef_a; end
        OP_SQ:     begin ma <= x1; mb <= x1; end
        OP_TRIPLE: begin ma <= three; mb <= acc; end
        OP_QMUL:   begin ma <= qm; mb <= t1; end
        OP_SLOPE:  begin ma <= num; mb <= t0; end
        OP_MSQ:    begin ma <= m; mb <= m; end
        OP_MY:     begin ma <= m; mb <= sub_mod(x1, x3, modulus); end
        OP_DIV: begin
          dq  <= r0;
          rem <= '0;
        end
        OP_CHORD: begin
          num <= sub_mod(y2, y1, modulus);
          den <= sub_mod(x2, x1, modulus);
        end
        OP_TANGENT: begin
          num <= add_mod(acc, aa, modulus);
          den <= add_mod(y1, y1, modulus);
        end
        OP_INV_INIT: begin
          r0 <= modulus;
          r1 <= den;
          t0 <= '0;
          t1 <= one;
        end
        OP_INV_STEP: begin
          r0 <= r1;
          r1 <= rem;
          t0 <= t1;
          t1 <= sub_mod(t0, acc, modulus);
        end
        OP_X3: x3 <= sub_mod(sub_mod(acc, x1, modulus), x2, modulus);
        OP_FIN: begin
          sum_x       <= x3;
          sum_y       <= sub_mod(acc, y1, modulus);
          at_infinity <= 1'b0;
        end
        OP_INF: begin
          sum_x       <= '0;
          sum_y       <= '0;
          at_infinity <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ec_affine_point_add_modp_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ec_affine_point_add_modp_top
// Affine point addition on y^2 = x^3 + a*x + b over a prime field.
// ----------------------------------------------------------------------------
// Takes one word (px,py,qx,qy) at a time and returns one word holding P+Q.
// Inputs and coef_a are reduced modulo the modulus first. Distinct x uses the
// chord slope, equal points the tangent slope (3x^2+a)/(2y); opposite points,
// a doubling with y equal to zero, or a modulus below two give (0,0) with
// at_infinity set. Every field multiplication runs on one bit-serial modular
// multiplier, and the inverse by extended Euclid uses a restoring divider for
// its quotients. A doubling runs two more multiplier operations than a sum
// with distinct x, and the number of Euclid rounds is at most about
// 1.44 * FIELD_BITS. A result waits in the output register until taken, and
// the next word can be accepted in the cycle after that, so no new word is
// taken while one is in work or its result waits.
// Write modulus (index 0) and coef_a (index 1) only while no word is in work.
// ----------------------------------------------------------------------------
module ec_affine_point_add_modp_top #(
  parameter int FIELD_BITS = ecap_pkg::FIELD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [ecap_pkg::REG_IDX_BITS-1:0] cfg_index,
  input  wire logic [FIELD_BITS-1:0]             cfg_data,
  ecap_in_if.sink                                in_ch,
  ecap_out_if.source                             out_ch
);
  import ecap_pkg::*;

  ecap_cmd_t cmd;
  ecap_sts_t sts;

  // Sequencer: handshakes and the micro-operation program
  ecap_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: registers, serial multiplier, divider, output word
  ecap_dp #(.W(FIELD_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .px          (in_ch.px),
    .py          (in_ch.py),
    .qx          (in_ch.qx),
    .qy          (in_ch.qy),
    .cmd         (cmd),
    .sts         (sts),
    .sum_x       (out_ch.sum_x),
    .sum_y       (out_ch.sum_y),
    .at_infinity (out_ch.at_infinity)
  );

`ifndef SYNTHESIS
  // A point at infinity always carries zero coordinates
  a_inf_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.at_infinity |-> out_ch.sum_x == '0 && out_ch.sum_y == '0)
    else $error("infinity word with nonzero coordinates");

  // Never take a new word while a result waits
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while result pending");

  // A multicycle operation cannot finish on the cycle after it starts
  a_engine: assert property (@(posedge clk) disable iff (rst)
    cmd.go && is_multi(cmd.op) |=> !sts.done)
    else $error("engine done too early");
`endif

endmodule
`default_nettype wire
